### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/psd3_pkg.sv
// Shared widths and word types for the point to segment distance pipeline.
package psd3_pkg;
  localparam int unsigned CoordW = 24;
  localparam int unsigned PosBits = 16;
  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned DotW = ProdW + 1;
  localparam int unsigned PosW = PosBits + 1;
  localparam int unsigned OffProdW = PosW + 1 + DiffW;
  localparam int unsigned DeltaW = OffProdW - PosBits;
  localparam int unsigned SqW = 2 * DeltaW;
  localparam int unsigned SumW = SqW + 2;
  localparam int unsigned RootW = SumW / 2;
  localparam int unsigned RemW = RootW + 2;
  localparam int unsigned DistW = CoordW + 1;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
  } in_word_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [PosW-1:0]  position;
  } out_word_t;
endpackage

### hw/rtl/point_segment_distance_3d.sv
// Point to segment distance in 3D: 1 word/cycle accepted while stall_o is low.
// Stages: differences, products, sums, 16 divide steps, offset multiply, delta, squares,
// sum of squares and 28 square root steps, each one bit per registered stage.
// A full pipeline of fixed depth; throughput is one word per cycle while the output drains.
// A two-entry output (register plus skid) parts the sides, so stall_o is registered.
// Reset (rst_ni low, asynchronous) clears all valid bits and the skid; no clearing pass.
module point_segment_distance_3d import psd3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  in_word_t  data_i,
  output logic      valid_o,
  input  logic      stall_i,
  output out_word_t data_o
);
`include "assert_macros.svh"

  typedef struct packed {
    logic [2:0][DiffW-1:0] v;
    logic [2:0][DiffW-1:0] w;
  } vec_t;

  typedef struct packed {
    logic [ProdW-1:0]       len2;
    logic [ProdW-1:0]       r;
    logic [PosBits-1:0]     q;
    logic                   t_zero;
    logic                   t_one;
    vec_t                   vw;
  } div_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [SumW-1:0]  n;
    logic [PosW-1:0]  t;
  } sqrt_t;

  logic en;
  logic skid_full_q, out_valid_q;
  out_word_t out_q, skid_q;

  assign en = !skid_full_q;
  assign stall_o = skid_full_q;

  // stage 1: differences
  logic v1_q; vec_t vw1_q;
  // stage 2: products
  logic v2_q; vec_t vw2_q;
  logic [2:0][ProdW-1:0] pvv_q, pwv_q;
  // stage 3: sums
  logic v3_q; vec_t vw3_q;
  logic [ProdW-1:0] len2_q;
  logic signed [DotW-1:0] dot_q;
  // divider
  logic [PosBits:0] dv_q;
  div_t div_q [PosBits+1];
  // offset multiply
  logic vm_q; logic [PosW-1:0] tm_q; vec_t vwm_q;
  logic [2:0][OffProdW-1:0] off_q;
  // delta
  logic vd_q; logic [PosW-1:0] td_q;
  logic [2:0][DeltaW-1:0] d_q;
  // squares
  logic vs_q; logic [PosW-1:0] ts_q;
  logic [2:0][SqW-1:0] sq_q;
  // sum
  logic vn_q; logic [PosW-1:0] tn_q;
  logic [SumW-1:0] sum_q;
  // square root
  logic [RootW:0] sv_q;
  sqrt_t sqrt_q [RootW+1];

  logic [PosW-1:0] t_fin;
  div_t div0_d;
  sqrt_t sqrt0_d;
  out_word_t res;

  always_comb begin
    div0_d = '0;
    div0_d.len2 = len2_q;
    div0_d.vw = vw3_q;
    div0_d.t_zero = (len2_q == '0) || (dot_q <= 0);
    div0_d.t_one = !div0_d.t_zero && (dot_q[ProdW-1:0] >= len2_q);
    div0_d.r = (div0_d.t_zero || div0_d.t_one) ? '0 : dot_q[ProdW-1:0];
  end

  always_comb begin
    if (div_q[PosBits].t_one) begin
      t_fin = PosW'(1) << PosBits;
    end else if (div_q[PosBits].t_zero) begin
      t_fin = '0;
    end else begin
      t_fin = {1'b0, div_q[PosBits].q};
    end
  end

  always_comb begin
    sqrt0_d = '0;
    sqrt0_d.n = sum_q;
    sqrt0_d.t = tn_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      dv_q <= '0; vm_q <= 1'b0; vd_q <= 1'b0; vs_q <= 1'b0; vn_q <= 1'b0;
      sv_q <= '0;
    end else if (en) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q;
      dv_q <= {dv_q[PosBits-1:0], v3_q};
      vm_q <= dv_q[PosBits]; vd_q <= vm_q; vs_q <= vd_q; vn_q <= vs_q;
      sv_q <= {sv_q[RootW-1:0], vn_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vw1_q.v[0] <= DiffW'($signed(data_i.end_x) - $signed(data_i.start_x));
      vw1_q.v[1] <= DiffW'($signed(data_i.end_y) - $signed(data_i.start_y));
      vw1_q.v[2] <= DiffW'($signed(data_i.end_z) - $signed(data_i.start_z));
      vw1_q.w[0] <= DiffW'($signed(data_i.point_x) - $signed(data_i.start_x));
      vw1_q.w[1] <= DiffW'($signed(data_i.point_y) - $signed(data_i.start_y));
      vw1_q.w[2] <= DiffW'($signed(data_i.point_z) - $signed(data_i.start_z));
      vw2_q <= vw1_q;
      for (int i = 0; i < 3; i++) begin
        pvv_q[i] <= ProdW'($signed(vw1_q.v[i]) * $signed(vw1_q.v[i]));
        pwv_q[i] <= ProdW'($signed(vw1_q.w[i]) * $signed(vw1_q.v[i]));
      end
      vw3_q <= vw2_q;
      len2_q <= pvv_q[0] + pvv_q[1] + pvv_q[2];
      dot_q <= DotW'($signed(pwv_q[0])) + DotW'($signed(pwv_q[1]))
             + DotW'($signed(pwv_q[2]));
      div_q[0] <= div0_d;
      tm_q <= t_fin;
      vwm_q <= div_q[PosBits].vw;
      for (int i = 0; i < 3; i++) begin
        off_q[i] <= OffProdW'($signed({1'b0, t_fin})
                    * $signed(div_q[PosBits].vw.v[i]));
      end
      td_q <= tm_q;
      for (int i = 0; i < 3; i++) begin
        // floor shift: arithmetic right shift rounds toward minus infinity
        d_q[i] <= DeltaW'($signed(vwm_q.w[i]))
                - DeltaW'($signed(off_q[i]) >>> PosBits);
      end
      ts_q <= td_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SqW'($signed(d_q[i]) * $signed(d_q[i]));
      end
      tn_q <= ts_q;
      sum_q <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      sqrt_q[0] <= sqrt0_d;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < PosBits; k++) begin : g_div
    logic [ProdW:0] r2;
    logic ge;
    div_t nxt;
    always_comb begin
      r2 = {div_q[k].r, 1'b0};
      ge = r2 >= {1'b0, div_q[k].len2};
      nxt = div_q[k];
      nxt.r = ge ? ProdW'(r2 - {1'b0, div_q[k].len2}) : r2[ProdW-1:0];
      nxt.q = {div_q[k].q[PosBits-2:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[k+1] <= nxt;
      end
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    logic [RemW+1:0] acc, trial;
    logic ge;
    sqrt_t nxt;
    always_comb begin
      acc = {sqrt_q[k].rem, sqrt_q[k].n[SumW-1 -: 2]};
      trial = (RemW+2)'({sqrt_q[k].root, 2'b01});
      ge = acc >= trial;
      nxt = sqrt_q[k];
      nxt.rem = ge ? RemW'(acc - trial) : acc[RemW-1:0];
      nxt.root = {sqrt_q[k].root[RootW-2:0], ge};
      nxt.n = {sqrt_q[k].n[SumW-3:0], 2'b00};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sqrt_q[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    res.position = sqrt_q[RootW].t;
    if (|sqrt_q[RootW].root[RootW-1:DistW]) begin
      res.distance = '1;
    end else begin
      res.distance = sqrt_q[RootW].root[DistW-1:0];
    end
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (!stall_i) begin
        skid_full_q <= 1'b0;
      end
    end else if (sv_q[RootW]) begin
      if (out_valid_q && stall_i) begin
        skid_full_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (!stall_i) begin
        out_q <= skid_q;
      end
    end else if (sv_q[RootW]) begin
      if (out_valid_q && stall_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign valid_o = out_valid_q;
  assign data_o = out_q;

  `ASSERT_ALWAYS(a_skid_needs_out, clk_i, rst_ni, !skid_full_q || out_valid_q,
    "skid holds a word while the output is empty")
  `ASSERT_ALWAYS(a_pos_range, clk_i, rst_ni,
    !valid_o || data_o.position <= (PosW'(1) << PosBits), "position above one")
  `ASSERT_NEXT(a_skid_drain, clk_i, rst_ni, skid_full_q && !stall_i,
    !skid_full_q && valid_o, "skid did not drain into the output")
endmodule

### tb/point_segment_distance_3d_test.sv
// Self-checking testbench for the 3D point to segment distance pipeline.
`timescale 1ns / 100ps

module point_segment_distance_3d_test;
  import psd3_pkg::*;

  localparam int unsigned LatencyCycles = 55;
  localparam longint unsigned CycleLimit = 2000000;
  localparam longint unsigned DistMax = (64'd1 << DistW) - 1;
  localparam longint unsigned PosOne = 64'd1 << PosBits;
  localparam int unsigned RandomWords = 1300;

  logic      clk_i;
  logic      rst_ni;
  logic      valid_i;
  logic      stall_o;
  in_word_t  data_i;
  logic      valid_o;
  logic      stall_i;
  out_word_t data_o;

  out_word_t       expected_q[$];
  int unsigned     mismatch_count;
  longint unsigned cycle_count;
  bit              rx_stall_enable;

  point_segment_distance_3d DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .data_i (data_i),
    .valid_o(valid_o),
    .stall_i(stall_i),
    .data_o (data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Project the point onto the segment and measure the gap to the closest point.
  function automatic out_word_t segment_distance(in_word_t w);
    longint signed   pnt[3], sta[3], fin[3], vv[3], ww[3];
    longint signed   dot, off, dlt;
    longint unsigned len2, tpos, rem, sum, dist_val;
    out_word_t       res;
    pnt = '{w.point_x, w.point_y, w.point_z};
    sta = '{w.start_x, w.start_y, w.start_z};
    fin = '{w.end_x, w.end_y, w.end_z};
    len2 = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      vv[i] = fin[i] - sta[i];
      ww[i] = pnt[i] - sta[i];
      len2 += vv[i] * vv[i];
      dot += ww[i] * vv[i];
    end
    if (len2 == 0 || dot <= 0) begin
      tpos = 0;
    end else if (longint'(unsigned'(dot)) >= len2) begin
      tpos = PosOne;
    end else begin
      rem = dot;
      tpos = 0;
      for (int i = 0; i < PosBits; i++) begin
        rem <<= 1;
        tpos <<= 1;
        if (rem >= len2) begin
          rem -= len2;
          tpos |= 1;
        end
      end
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      off = (longint'(tpos) * vv[i]) >>> PosBits;   // arithmetic shift floors
      dlt = ww[i] - off;
      sum += dlt * dlt;
    end
    dist_val = isqrt64(sum);
    if (dist_val > DistMax) dist_val = DistMax;
    res.distance = dist_val[DistW-1:0];
    res.position = tpos[PosW-1:0];
    return res;
  endfunction

  function automatic int unsigned gap_length();
    if ($urandom_range(99) < 90) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // Send one word after an optional random gap, hold it while stalled, and queue its expectation.
  task automatic send_word(in_word_t w, bit allow_gap);
    int unsigned gap;
    gap = allow_gap ? gap_length() : 0;
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    data_i  <= w;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    expected_q.push_back(segment_distance(w));
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    valid_i <= 1'b0;
  endtask

  function automatic logic [CoordW-1:0] rand_coord(int unsigned span_bits);
    logic [CoordW-1:0] c;
    c = CoordW'($urandom);
    if (span_bits < CoordW) c = $signed(c[CoordW-1:0]) >>> (CoordW - span_bits);
    return c;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int unsigned span;
    span = ($urandom_range(3) == 0) ? CoordW : $urandom_range(CoordW, 4);
    w.point_x = rand_coord(span);
    w.point_y = rand_coord(span);
    w.point_z = rand_coord(span);
    w.start_x = rand_coord(span);
    w.start_y = rand_coord(span);
    w.start_z = rand_coord(span);
    case ($urandom_range(9))
      0: begin
        w.end_x = w.start_x;
        w.end_y = w.start_y;
        w.end_z = w.start_z;
      end
      1: begin
        // near-degenerate segment
        w.end_x = w.start_x + $signed(3'($urandom_range(7)) - 3'sd3);
        w.end_y = w.start_y;
        w.end_z = w.start_z + CoordW'(1);
      end
      default: begin
        w.end_x = rand_coord(span);
        w.end_y = rand_coord(span);
        w.end_z = rand_coord(span);
      end
    endcase
    return w;
  endfunction

  function automatic in_word_t make_word(int px, int py, int pz, int sx, int sy, int sz,
                                         int ex, int ey, int ez);
    in_word_t w;
    w.point_x = CoordW'(px); w.point_y = CoordW'(py); w.point_z = CoordW'(pz);
    w.start_x = CoordW'(sx); w.start_y = CoordW'(sy); w.start_z = CoordW'(sz);
    w.end_x = CoordW'(ex); w.end_y = CoordW'(ey); w.end_z = CoordW'(ez);
    return w;
  endfunction

  // Extremes, degenerate segment and clamping at both ends.
  task automatic test_directed();
    int mx;
    int mn;
    mx = 8388607;
    mn = -8388608;
    send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_word(make_word(256, 512, -768, 0, 0, 0, 0, 0, 0), 1'b0);
    send_word(make_word(mx, mx, mx, mn, mn, mn, mn, mn, mn), 1'b0);
    send_word(make_word(mn, mn, mn, mx, mx, mx, mx, mx, mx), 1'b0);
    send_word(make_word(mx, mx, mx, mn, mn, mn, mx, mx, mx), 1'b0);
    send_word(make_word(mx, mn, mx, mn, mx, mn, mn, mx, mn), 1'b0);
    send_word(make_word(-512, 100, 0, 0, 0, 0, 256, 0, 0), 1'b0);
    send_word(make_word(0, 100, 0, 0, 0, 0, 256, 0, 0), 1'b0);
    send_word(make_word(256, 100, 0, 0, 0, 0, 256, 0, 0), 1'b0);
    send_word(make_word(1000, 7, 3, 0, 0, 0, 256, 0, 0), 1'b0);
    send_word(make_word(128, 50, -9, 0, 0, 0, 256, 0, 0), 1'b0);
    send_word(make_word(1, 1, 1, 0, 0, 0, 3, 0, 0), 1'b0);
    send_word(make_word(-1, -1, -1, 0, 0, 0, -3, -5, 7), 1'b0);
    send_word(make_word(mn, mx, 0, mx, mn, 0, mx, mn, 1), 1'b0);
    send_word(make_word(mx, mx, mx, mn, mn, mn, mn, mn, mn + 1), 1'b0);
    send_word(make_word(mn, 0, mx, 0, 0, 0, 1, 0, 0), 1'b0);
    send_word(make_word(12345, -6789, 4242, -100, 200, -300, 5000, -4000, 3000), 1'b0);
    send_word(make_word(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b0);
    end_burst();
  endtask

  task automatic test_random_stream();
    for (int n = 0; n < RandomWords; n++) begin
      if (n == RandomWords / 3) rx_stall_enable = 1'b0;
      if (n == RandomWords / 2) rx_stall_enable = 1'b1;
      send_word(rand_word(), (n / 200) % 3 != 1);
    end
    end_burst();
  endtask

  // Receiver stall: short random stalls, occasional long ones, and quiet stretches.
  initial begin
    int unsigned hold;
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_stall_enable && $urandom_range(99) < 25) begin
        hold = gap_length() + 1;
        stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      stall_i <= 1'b0;
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    out_word_t exp_word;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result word: distance %0d position %0d",
                   data_o.distance, data_o.position);
      end else begin
        exp_word = expected_q.pop_front();
        if (data_o.distance !== exp_word.distance || data_o.position !== exp_word.position) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: distance exp %0d got %0d, position exp %0d got %0d",
                     exp_word.distance, data_o.distance, exp_word.position, data_o.position);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    mismatch_count  = 0;
    cycle_count     = 0;
    rx_stall_enable = 1'b1;
    valid_i = 1'b0;
    data_i  = '0;
    rst_ni  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_stream();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LatencyCycles + 10) @(negedge clk_i);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/psd3_pkg.sv
hw/rtl/point_segment_distance_3d.sv
tb/point_segment_distance_3d_test.sv
